// File: rtl/core/pgb_pkg.sv
// Shared types and constants for the palette glyph blitter.
// Used by pgb_front, pgb_queue, pgb_back and palette_glyph_blit_top.
package pgb_pkg;

  // Input opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_BITMAP = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAL_0_3    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAL_4_7    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAL_8_11   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAL_12_15  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUF_WINDOW = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIN   = 3'd5;

  localparam int unsigned CFG_DATA_BITS = 64;
  localparam logic [3:0]  NIB_MASK      = 4'hF;

  // Pixel queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;

  // Configuration as seen by front and back
  typedef struct packed {
    logic [3:0][CFG_DATA_BITS-1:0] palette;
    logic [CFG_DATA_BITS-1:0]      buf_win;
    logic [CFG_DATA_BITS-1:0]      clip_win;
  } pgb_cfg_t;

  // One pixel write waiting for index math and color lookup
  typedef struct packed {
    logic [15:0] dy;    // row offset from buffer window top
    logic [15:0] dx;    // column offset from buffer window left
    logic [3:0]  nib;   // palette entry
    logic        last;  // final write of its byte
  } pgb_entry_t;

endpackage

// File: rtl/core/pgb_front.sv
// Front end: accepts start and bitmap items, walks the glyph cursor and
// queues the pixels that fall inside both windows. Depends on pgb_pkg.
module pgb_front import pgb_pkg::*; #(
  parameter int MAX_GLYPH_DIM = 1023
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic signed [15:0] glyph_x,
  input  logic signed [15:0] glyph_y,
  input  logic [9:0]        glyph_width,
  input  logic [9:0]        glyph_height,
  input  logic [7:0]        bitmap_byte,
  input  pgb_cfg_t          cfg,
  output logic              q_push,
  output pgb_entry_t        q_entry,
  input  logic              q_full
);

  localparam int DIM_BITS = $clog2(MAX_GLYPH_DIM + 1);
  localparam int CMP_BITS = (DIM_BITS > 10) ? DIM_BITS + 1 : 11;

  // Glyph box and cursor
  logic [15:0]         origin_x;
  logic [15:0]         origin_y;
  logic [DIM_BITS-1:0] box_width;
  logic [DIM_BITS-1:0] box_height;
  logic [DIM_BITS-1:0] column_count;
  logic [DIM_BITS-1:0] row_count;

  // Pending pixels of the last byte
  logic [1:0]  pend_valid;
  pgb_entry_t  pend_ent [2];

  // Cursor step for one nibble
  typedef struct packed {
    logic                in_box;
    logic                hit;
    logic [15:0]         dx;
    logic [15:0]         dy;
    logic [DIM_BITS-1:0] col_next;
    logic [DIM_BITS-1:0] row_next;
  } step_t;

  function automatic logic win_hit(logic [CFG_DATA_BITS-1:0] w,
                                   logic [16:0] x, logic [16:0] y);
    logic signed [16:0] x1, y1, x2, y2;
    x1 = {w[15], w[15:0]};
    y1 = {w[31], w[31:16]};
    x2 = {w[47], w[47:32]};
    y2 = {w[63], w[63:48]};
    return ($signed(x) >= x1) && ($signed(x) <= x2) &&
           ($signed(y) >= y1) && ($signed(y) <= y2);
  endfunction

  function automatic step_t pix_step(logic [DIM_BITS-1:0] col,
                                     logic [DIM_BITS-1:0] row);
    step_t             s;
    logic [16:0]       x, y;
    logic [DIM_BITS:0] col_inc;
    s.in_box = (box_width != '0) && (row < box_height);
    x = {origin_x[15], origin_x} + 17'(col);
    y = {origin_y[15], origin_y} + 17'(row);
    s.hit = s.in_box && win_hit(cfg.buf_win, x, y) && win_hit(cfg.clip_win, x, y);
    s.dx = 16'(x - {cfg.buf_win[15], cfg.buf_win[15:0]});
    s.dy = 16'(y - {cfg.buf_win[31], cfg.buf_win[31:16]});
    col_inc = {1'b0, col} + (DIM_BITS+1)'(1);
    if (!s.in_box) begin
      s.col_next = col;
      s.row_next = row;
    end else if (col_inc >= {1'b0, box_width}) begin
      s.col_next = '0;
      s.row_next = row + DIM_BITS'(1);
    end else begin
      s.col_next = col_inc[DIM_BITS-1:0];
      s.row_next = row;
    end
    return s;
  endfunction

  step_t s0, s1;
  logic  accept;
  logic  [1:0] pend_after;

  always_comb begin
    s0 = pix_step(column_count, row_count);
    s1 = pix_step(s0.col_next, s0.row_next);
  end

  // Push one pending pixel a cycle while the queue is not full, high nibble first
  assign q_push  = (pend_valid != 2'b00) && !q_full;
  assign q_entry = pend_valid[0] ? pend_ent[0] : pend_ent[1];

  always_comb begin
    pend_after = pend_valid;
    if (q_push) begin
      if (pend_valid[0]) pend_after[0] = 1'b0;
      else               pend_after[1] = 1'b0;
    end
  end

  // Take a new item once the previous byte's pixels are all queued
  assign in_stall = (pend_after != 2'b00);
  assign accept   = in_valid && !in_stall;

  // Clamp for the box size
  function automatic logic [DIM_BITS-1:0] clamp_dim(logic [9:0] v);
    if (CMP_BITS'(v) > CMP_BITS'(MAX_GLYPH_DIM)) return DIM_BITS'(MAX_GLYPH_DIM);
    return DIM_BITS'(v);
  endfunction

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 2'b00;
      origin_x     <= '0;
      origin_y     <= '0;
      box_width    <= '0;
      box_height   <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (accept && opcode == OP_BITMAP) pend_valid <= {s1.hit, s0.hit};
      else                               pend_valid <= pend_after;
      if (accept) begin
        if (opcode == OP_START) begin
          origin_x     <= glyph_x;
          origin_y     <= glyph_y;
          box_width    <= clamp_dim(glyph_width);
          box_height   <= clamp_dim(glyph_height);
          column_count <= '0;
          row_count    <= '0;
        end else begin
          column_count <= s1.col_next;
          row_count    <= s1.row_next;
        end
      end
    end
  end

  // Pending pixel payload
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_BITMAP) begin
      pend_ent[0] <= '{dy: s0.dy, dx: s0.dx, nib: bitmap_byte[7:4] & NIB_MASK,
                       last: s0.hit && !s1.hit};
      pend_ent[1] <= '{dy: s1.dy, dx: s1.dx, nib: bitmap_byte[3:0] & NIB_MASK,
                       last: s1.hit};
    end
  end

endmodule

// File: rtl/core/pgb_queue.sv
// Short FIFO of pixel writes between front and back.
// Depends on pgb_pkg for the entry type and depth.
module pgb_queue import pgb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pgb_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output pgb_entry_t rd_entry,
  output logic       empty
);

  pgb_entry_t           mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full     = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      count <= count + (QPTR_BITS+1)'(1);
      else if (pop && !push) count <= count - (QPTR_BITS+1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_entry;
  end

endmodule

// File: rtl/core/pgb_back.sv
// Back end: buffer index multiply-add and palette lookup, two stages
// ending in the output register. Depends on pgb_pkg.
module pgb_back import pgb_pkg::*; #(
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pgb_cfg_t              cfg,
  input  logic                  q_empty,
  input  pgb_entry_t            q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] buf_index,
  output logic [15:0]           pixel_color,
  output logic                  last
);

  // Stage A: product and color
  logic                  a_valid;
  logic [INDEX_BITS-1:0] a_prod;
  logic [15:0]           a_dx;
  logic [15:0]           a_color;
  logic                  a_last;

  logic        en_a, en_b;
  logic [16:0] buf_width;
  logic [32:0] prod;
  logic [15:0] color;

  assign en_b  = !out_valid || !out_stall;
  assign en_a  = !a_valid || en_b;
  assign q_pop = !q_empty && en_a;

  // Buffer row pitch, 1..65536 for a non-empty window
  assign buf_width = 17'({cfg.buf_win[47], cfg.buf_win[47:32]}
                         - {cfg.buf_win[15], cfg.buf_win[15:0]} + 17'd1);
  assign prod  = 33'(q_entry.dy) * 33'(buf_width);
  assign color = cfg.palette[q_entry.nib[3:2]][16*q_entry.nib[1:0] +: 16];

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_valid   <= q_pop;
      if (en_b) out_valid <= a_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_prod  <= prod[INDEX_BITS-1:0];
      a_dx    <= q_entry.dx;
      a_color <= color;
      a_last  <= q_entry.last;
    end
    if (en_b && a_valid) begin
      buf_index   <= a_prod + INDEX_BITS'(a_dx);
      pixel_color <= a_color;
      last        <= a_last;
    end
  end

endmodule

// File: rtl/core/palette_glyph_blit_top.sv
// Top level of the 4bpp palette glyph blitter: config registers, front,
// pixel queue and back. Depends on pgb_pkg, pgb_front, pgb_queue, pgb_back.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_stall  | opcode, glyph_x/y, glyph_width/height, bitmap_byte
//  output  | out_valid / out_stall| buf_index, pixel_color, last
//  config  | cfg_we               | cfg_index, cfg_data
//
// A bitmap byte whose pixels both land holds the input while the second pixel is queued,
// since the front queues one pixel at a time; a start item queues none.
// The first write of a byte passes the pending register, queue, stage A and output register.
// Reset clears config registers, glyph box, cursor, queue and pipeline valids.
// A four-entry queue lets the front keep taking items while the output stalls.
module palette_glyph_blit_top import pgb_pkg::*; #(
  parameter int MAX_GLYPH_DIM = 1023,
  parameter int INDEX_BITS    = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic signed [15:0]       glyph_x,
  input  logic signed [15:0]       glyph_y,
  input  logic [9:0]               glyph_width,
  input  logic [9:0]               glyph_height,
  input  logic [7:0]               bitmap_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [INDEX_BITS-1:0]    buf_index,
  output logic [15:0]              pixel_color,
  output logic                     last
);

  pgb_cfg_t   cfg;
  logic       q_push, q_pop, q_full, q_empty;
  pgb_entry_t q_wr, q_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index) inside
        REG_PAL_0_3, REG_PAL_4_7, REG_PAL_8_11, REG_PAL_12_15: begin
          cfg.palette[cfg_index[1:0]] <= cfg_data;
        end
        REG_BUF_WINDOW: begin
          cfg.buf_win <= cfg_data;
        end
        REG_CLIP_WIN: begin
          cfg.clip_win <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  pgb_front #(
    .MAX_GLYPH_DIM(MAX_GLYPH_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .glyph_x      (glyph_x),
    .glyph_y      (glyph_y),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .bitmap_byte  (bitmap_byte),
    .cfg          (cfg),
    .q_push       (q_push),
    .q_entry      (q_wr),
    .q_full       (q_full)
  );

  pgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty)
  );

  pgb_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_entry     (q_rd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buf_index   (buf_index),
    .pixel_color (pixel_color),
    .last        (last)
  );

  // Queue never written when full
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("pixel queue overflow");

  // Queue never read when empty
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pixel queue underflow");

  // A start item leaves nothing pending, so the next item is taken at once
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode == OP_START) |=> !in_stall)
    else $error("front stalled after start item");

  // Reset empties the output stage
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for palette_glyph_blit_top: scripted glyphs, then random ones.
// Each accepted item runs through a behavioral blitter model; the writes it should cause
// are queued, typed in or from the model. Depends on pgb_pkg and palette_glyph_blit_top.
`timescale 1ns / 1ps

module tb_top;
  import pgb_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 12;
  localparam int TOTAL_ITEMS  = 1850;
  localparam int CALM_ITEMS   = 250;
  localparam int MAX_DIM      = 1023;
  localparam int IDX_W        = 24;
  localparam int MAX_PRINTS   = 100;
  localparam logic [1:0] PREDICTED = 2'd3;  // row is checked against the blitter model
  localparam logic [63:0] PAL_RAMP_0 = 64'h3333_2222_1111_0000;
  localparam logic [63:0] PAL_RAMP_1 = 64'h7777_6666_5555_4444;
  localparam logic [63:0] PAL_RAMP_2 = 64'hBBBB_AAAA_9999_8888;
  localparam logic [63:0] PAL_RAMP_3 = 64'hFFFF_EEEE_DDDD_CCCC;

  typedef struct packed {
    logic        op;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [9:0]  gw;
    logic [9:0]  gh;
    logic [7:0]  bits;
  } blit_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [15:0]      color;
    logic             last;
  } pix_wr_t;

  // One line of the glyph script: either a config set to load, or an item
  // with its writes typed in (tn = count) or left to the model.
  typedef struct packed {
    logic             setup;
    logic [1:0]       cset;
    blit_item_t       it;
    logic [1:0]       tn;
    logic [IDX_W-1:0] ti0;
    logic [15:0]      tc0;
    logic [IDX_W-1:0] ti1;
    logic [15:0]      tc1;
  } script_row_t;

  // DUT ports
  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = OP_START;
  logic signed [15:0]       glyph_x = '0;
  logic signed [15:0]       glyph_y = '0;
  logic [9:0]               glyph_width = '0;
  logic [9:0]               glyph_height = '0;
  logic [7:0]               bitmap_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         buf_index;
  logic [15:0]              pixel_color;
  logic                     last;

  // Blitter model state and config copy
  logic [63:0] pal [4] = '{default: '0};
  logic [63:0] bwin = '0;
  logic [63:0] cwin = '0;
  int org_x = 0, org_y = 0, box_w = 0, box_h = 0, col_cnt = 0, row_cnt = 0;

  pix_wr_t pending_wr [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  bit calm = 1'b0;

  palette_glyph_blit_top #(
    .MAX_GLYPH_DIM(MAX_DIM),
    .INDEX_BITS   (IDX_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .glyph_x     (glyph_x),
    .glyph_y     (glyph_y),
    .glyph_width (glyph_width),
    .glyph_height(glyph_height),
    .bitmap_byte (bitmap_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buf_index   (buf_index),
    .pixel_color (pixel_color),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: timeout, writes still pending: %0d", pending_wr.size());
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic report(input string what);
    if (mismatch_count < MAX_PRINTS) $display("tb_top: %s", what);
    mismatch_count++;
  endtask

  // Window register layout: x1 lowest, then y1, x2, y2
  function automatic logic [63:0] rect(input int x1, input int y1, input int x2, input int y2);
    return {16'(y2), 16'(x2), 16'(y1), 16'(x1)};
  endfunction

  function automatic bit in_rect(input logic [63:0] w, input int x, input int y);
    return x >= int'($signed(w[15:0])) && x <= int'($signed(w[47:32])) &&
           y >= int'($signed(w[31:16])) && y <= int'($signed(w[63:48]));
  endfunction

  // One nibble: advance the cursor, report a write if the pixel lands in both windows
  function automatic bit next_pixel(input logic [3:0] nib, output pix_wr_t wr);
    int x, y;
    longint bx1, by1, bw, ix;
    wr = '0;
    if (box_w == 0 || row_cnt >= box_h) return 1'b0;
    x = org_x + col_cnt;
    y = org_y + row_cnt;
    next_pixel = 1'b0;
    if (in_rect(bwin, x, y) && in_rect(cwin, x, y)) begin
      bx1 = longint'($signed(bwin[15:0]));
      by1 = longint'($signed(bwin[31:16]));
      bw  = longint'($signed(bwin[47:32])) - bx1 + 1;
      ix  = (longint'(y) - by1) * bw + (longint'(x) - bx1);
      wr.idx   = ix[IDX_W-1:0];
      wr.color = pal[nib[3:2]][16*nib[1:0] +: 16];
      next_pixel = 1'b1;
    end
    col_cnt++;
    if (col_cnt >= box_w) begin
      col_cnt = 0;
      row_cnt++;
    end
  endfunction

  // Model of one accepted item: start latches the box, bitmap gives up to two writes
  function automatic void blit_predict(input blit_item_t it, output pix_wr_t [1:0] wr,
                                       output int n);
    pix_wr_t p;
    n = 0;
    wr = '0;
    if (it.op == OP_START) begin
      org_x = int'($signed(it.gx));
      org_y = int'($signed(it.gy));
      box_w = (int'(it.gw) > MAX_DIM) ? MAX_DIM : int'(it.gw);
      box_h = (int'(it.gh) > MAX_DIM) ? MAX_DIM : int'(it.gh);
      col_cnt = 0;
      row_cnt = 0;
    end else begin
      if (next_pixel(it.bits[7:4], p)) begin
        wr[n] = p;
        n++;
      end
      if (next_pixel(it.bits[3:0], p)) begin
        wr[n] = p;
        n++;
      end
      if (n > 0) wr[n-1].last = 1'b1;
    end
  endfunction

  // Drive one item and hold it until accepted; may idle first
  task automatic put_item(input blit_item_t it);
    int g;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      g = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= it.op;
    glyph_x      <= it.gx;
    glyph_y      <= it.gy;
    glyph_width  <= it.gw;
    glyph_height <= it.gh;
    bitmap_byte  <= it.bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send an item and queue its writes, typed in or from the model
  task automatic send_item(input script_row_t r);
    pix_wr_t [1:0] wr;
    int n;
    put_item(r.it);
    blit_predict(r.it, wr, n);
    if (r.tn != PREDICTED) begin
      n = int'(r.tn);
      wr[0] = '{r.ti0, r.tc0, r.tn == 2'd1};
      wr[1] = '{r.ti1, r.tc1, 1'b1};
    end
    for (int k = 0; k < n; k++) pending_wr.push_back(wr[k]);
  endtask

  // Stop sending and let every queued write come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_wr.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      REG_PAL_0_3, REG_PAL_4_7, REG_PAL_8_11, REG_PAL_12_15: pal[idx[1:0]] = d;
      REG_BUF_WINDOW: bwin = d;
      REG_CLIP_WIN:   cwin = d;
      default: ;
    endcase
  endtask

  // Load all six registers once the block has gone quiet
  task automatic apply_cfg(input logic [5:0][63:0] c);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_PAL_0_3,    c[0]);
    write_reg(REG_PAL_4_7,    c[1]);
    write_reg(REG_PAL_8_11,   c[2]);
    write_reg(REG_PAL_12_15,  c[3]);
    write_reg(REG_BUF_WINDOW, c[4]);
    write_reg(REG_CLIP_WIN,   c[5]);
    cfg_we <= 1'b0;
  endtask

  function automatic script_row_t item_row(input logic op, input int gx, input int gy,
      input int gw, input int gh, input logic [7:0] b, input logic [1:0] tn,
      input int ti0, input int tc0, input int ti1, input int tc1);
    item_row = '{1'b0, 2'd0, '{op, 16'(gx), 16'(gy), 10'(gw), 10'(gh), b}, tn,
                 IDX_W'(ti0), 16'(tc0), IDX_W'(ti1), 16'(tc1)};
  endfunction

  function automatic script_row_t cfg_row(input logic [1:0] k);
    cfg_row = '0;
    cfg_row.setup = 1'b1;
    cfg_row.cset  = k;
  endfunction

  // Output stall in random bursts
  always @(posedge clk) begin : drive_out_stall
    int left;
    if (left == 0 && !calm && $urandom_range(0, 99) < stall_pct) left = $urandom_range(1, 7);
    if (left != 0) begin
      out_stall <= 1'b1;
      left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted write with the oldest expected one
  always @(posedge clk) begin : check_writes
    pix_wr_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_wr.size() == 0) begin
        report($sformatf("unexpected write idx %h color %h last %b",
                         buf_index, pixel_color, last));
      end else begin
        want = pending_wr.pop_front();
        if (buf_index !== want.idx)
          report($sformatf("buf_index got %h want %h", buf_index, want.idx));
        if (pixel_color !== want.color)
          report($sformatf("pixel_color got %h want %h (idx %h)", pixel_color,
                           want.color, want.idx));
        if (last !== want.last)
          report($sformatf("last got %b want %b (idx %h)", last, want.last, want.idx));
      end
    end
  end

  initial begin : stimulus
    script_row_t       script [30];
    logic [5:0][63:0]  cfg_sets [4];
    logic [5:0][63:0]  c;
    script_row_t       r;
    blit_item_t        it;
    logic [63:0]       noise;
    int mode, x1, y1, cx1, cy1, wx, wy, gw, gh, nbytes, phase_end, glyph_no, kind;

    // Config sets for the script: ramp palette (entry n is n*0x1111) and various windows
    for (int k = 0; k < 4; k++) begin
      cfg_sets[k][0] = PAL_RAMP_0;
      cfg_sets[k][1] = PAL_RAMP_1;
      cfg_sets[k][2] = PAL_RAMP_2;
      cfg_sets[k][3] = PAL_RAMP_3;
    end
    cfg_sets[0][4] = rect(-8, -4, 7, 3);
    cfg_sets[0][5] = rect(-32768, -32768, 32767, 32767);
    cfg_sets[1][4] = rect(-8, -4, 7, 3);
    cfg_sets[1][5] = rect(5, -32768, 4, 32767);           // empty clip
    cfg_sets[2][4] = rect(-32768, -32768, 32767, 32767);
    cfg_sets[2][5] = rect(-32768, -32768, 32767, 32767);
    cfg_sets[3][4] = rect(32760, 32760, 32767, 32767);
    cfg_sets[3][5] = rect(32762, -32768, 32767, 32767);

    // Reset config: both windows are the single pixel (0,0), palette all zero
    script[0]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0, 0);  // no start yet
    script[1]  = item_row(OP_START, 0, 0, 1, 1, 8'h00, 0, 0, 0, 0, 0);
    script[2]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'hAB, 1, 0, 0, 0, 0);
    script[3]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h12, 0, 0, 0, 0, 0);  // past glyph end
    script[4]  = cfg_row(2'd0);
    script[5]  = item_row(OP_START, -8, -4, 3, 2, 8'h5C, 0, 0, 0, 0, 0);
    script[6]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h0F, 2, 0, 'h0000, 1, 'hFFFF);
    script[7]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h5A, 2, 2, 'h5555, 16, 'hAAAA);
    script[8]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h12, 2, 17, 'h1111, 18, 'h2222);
    script[9]  = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h34, 0, 0, 0, 0, 0);
    // Box straddling the right and bottom window edges
    script[10] = item_row(OP_START, 6, 2, 4, 3, 8'h00, PREDICTED, 0, 0, 0, 0);
    script[11] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h11, PREDICTED, 0, 0, 0, 0);
    script[12] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h22, PREDICTED, 0, 0, 0, 0);
    script[13] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h9C, PREDICTED, 0, 0, 0, 0);
    script[14] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'hE7, PREDICTED, 0, 0, 0, 0);
    script[15] = item_row(OP_START, 0, 0, 0, 5, 8'h00, 0, 0, 0, 0, 0);   // zero width
    script[16] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0, 0);
    script[17] = cfg_row(2'd1);
    script[18] = item_row(OP_START, -8, -4, 2, 2, 8'h00, 0, 0, 0, 0, 0);
    script[19] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h77, 0, 0, 0, 0, 0);
    // Full-range windows: index wraps, no coordinate wrap past 32767
    script[20] = cfg_row(2'd2);
    script[21] = item_row(OP_START, 32767, 32767, 1023, 1023, 8'h00, 0, 0, 0, 0, 0);
    script[22] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'hF0, 1, 'hFFFFFF, 'hFFFF, 0, 0);
    script[23] = item_row(OP_START, -32768, -32768, 1, 1, 8'h00, 0, 0, 0, 0, 0);
    script[24] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h8F, 1, 0, 'h8888, 0, 0);
    script[25] = cfg_row(2'd3);
    script[26] = item_row(OP_START, 32758, 32766, 16, 1023, 8'h00, PREDICTED, 0, 0, 0, 0);
    script[27] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h3C, PREDICTED, 0, 0, 0, 0);
    script[28] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'hD2, PREDICTED, 0, 0, 0, 0);
    script[29] = item_row(OP_BITMAP, 0, 0, 0, 0, 8'h6B, PREDICTED, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Scripted glyphs
    stall_pct = 25;
    gap_pct   = 25;
    foreach (script[i]) begin
      if (script[i].setup) apply_cfg(cfg_sets[script[i].cset]);
      else send_item(script[i]);
    end

    // Random phases: new config, then mostly whole glyphs with random content
    glyph_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      calm = (items_sent > TOTAL_ITEMS - CALM_ITEMS);
      stall_pct = calm ? 0 : 30 * $urandom_range(0, 2);
      gap_pct   = calm ? 0 : 25 * $urandom_range(0, 2);
      mode = $urandom_range(0, 9);
      case (mode)
        0: c = '0;
        1: c = '1;
        2: begin
          for (int k = 0; k < 4; k++) c[k] = {$urandom, $urandom};
          c[4] = rect(-32768, -32768, 32767, 32767);
          c[5] = c[4];
        end
        default: begin
          for (int k = 0; k < 4; k++) c[k] = {$urandom, $urandom};
          x1 = int'($urandom_range(0, 60)) - 30;
          y1 = int'($urandom_range(0, 60)) - 30;
          // a far edge below the near one gives an empty window now and then
          c[4] = rect(x1, y1, x1 + int'($urandom_range(0, 24)) - 2,
                      y1 + int'($urandom_range(0, 24)) - 2);
          if ($urandom_range(0, 1) == 0) begin
            c[5] = rect(-32768, -32768, 32767, 32767);
          end else begin
            cx1 = x1 + int'($urandom_range(0, 12)) - 4;
            cy1 = y1 + int'($urandom_range(0, 12)) - 4;
            c[5] = rect(cx1, cy1, cx1 + int'($urandom_range(0, 20)),
                        cy1 + int'($urandom_range(0, 20)));
          end
        end
      endcase
      apply_cfg(c);
      wx = (int'($signed(c[4][15:0])) + int'($signed(c[4][47:32]))) / 2;
      wy = (int'($signed(c[4][31:16])) + int'($signed(c[4][63:48]))) / 2;
      phase_end = items_sent + $urandom_range(120, 200);

      while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
        kind = $urandom_range(0, 99);
        r = '0;
        r.tn = PREDICTED;
        if (kind < 80) begin
          // whole glyph, sometimes cut short
          glyph_no++;
          if (glyph_no % 25 == 7) hold_until_drained();
          gw = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 10);
          gh = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 10);
          it.op   = OP_START;
          it.gx   = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                 : 16'(wx - 8 + int'($urandom_range(0, 16)));
          it.gy   = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                 : 16'(wy - 8 + int'($urandom_range(0, 16)));
          it.gw   = 10'(gw);
          it.gh   = 10'(gh);
          it.bits = 8'($urandom);
          r.it = it;
          send_item(r);
          nbytes = (gw * gh + 1) / 2 + $urandom_range(0, 2);
          if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes);
          if (nbytes > 40) nbytes = 40;
          for (int b = 0; b < nbytes; b++) begin
            it.op   = OP_BITMAP;
            it.bits = 8'($urandom);
            r.it = it;
            send_item(r);
          end
        end else if (kind < 92) begin
          // noise: every field random
          noise = {$urandom, $urandom};
          r.it = noise[$bits(blit_item_t)-1:0];
          send_item(r);
        end else begin
          // stray byte continuing whatever box is current
          it.op   = OP_BITMAP;
          it.bits = 8'($urandom);
          r.it = it;
          send_item(r);
        end
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
